### hw/rtl/eu_summer_time_offset_top_macros.svh
`ifndef EU_SUMMER_TIME_OFFSET_TOP_MACROS_SVH
`define EU_SUMMER_TIME_OFFSET_TOP_MACROS_SVH

// Immediate implication checked at every clock edge outside reset.
`define EUSTO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication whose consequent is due a fixed number of cycles later.
`define EUSTO_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("delayed check failed");

`endif

### hw/rtl/eusto_pkg.sv
`default_nettype none

package eusto_pkg;

    localparam int unsigned EUSTO_LATENCY = 8;

    localparam logic [31:0] LAST_SECOND_2099 = 32'd4102444799;
    localparam logic [12:0] SUMMER_OFFSET    = 13'd7200;
    localparam logic [12:0] WINTER_OFFSET    = 13'd3600;

    // floor(2^32 / 675): seconds >> 7 times this, >> 32, is the day or one less.
    localparam logic [22:0] DAY_RECIP        = 23'd6362914;
    localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
    localparam logic [17:0] SECONDS_PER_HOUR = 18'd3600;

    // Days from 1968-03-01 to 1970-01-01; dates count in March-based years.
    localparam logic [15:0] EPOCH_SHIFT      = 16'd671;
    // floor(2^24 / 1461): days times this, >> 24, is the leap cycle or one less.
    localparam logic [13:0] CYCLE_RECIP      = 14'd11483;
    localparam logic [10:0] DAYS_PER_CYCLE   = 11'd1461;

    // Day of the March-based year on which October 1 falls.
    localparam logic [8:0]  OCT_FIRST_DOY    = 9'd214;

    // x mod 7 for an 8-bit value, folding 3-bit digits since 8 = 1 mod 7.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = {2'b00, x[2:0]} + {2'b00, x[5:3]} + {3'b000, x[7:6]};
        s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/eu_summer_time_offset_top.sv
// Each start transfer yields one result, flagged by the done strobe.
// Throughput: one timestamp per cycle through an 8-stage pipeline; busy stays low.
// The day and leap-cycle splits each take a reciprocal multiply, a subtract and
// a correction stage. The receiver cannot stall, so results leave on done.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
`default_nettype none

module eu_summer_time_offset_top
    import eusto_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] utc_seconds,
    output logic             done,
    output logic             is_summer,
    output logic [12:0]      offset_seconds
);

    logic [EUSTO_LATENCY-1:0] valid_reg;
    logic [EUSTO_LATENCY-1:0] valid_next;

    logic [31:0] s1_t_reg;
    logic [31:0] s1_t_next;
    logic [15:0] s1_q_reg;
    logic [15:0] s1_q_next;
    logic [47:0] s1_prod;

    logic [15:0] s2_q_reg;
    logic [17:0] s2_r_reg;
    logic [17:0] s2_r_next;
    logic [32:0] s2_diff;

    logic [15:0] s3_dp_reg;
    logic [15:0] s3_dp_next;
    logic        s3_late_reg;
    logic        s3_late_next;
    logic        s3_ge;
    logic [17:0] s3_r;

    logic [5:0]  s4_c_reg;
    logic [5:0]  s4_c_next;
    logic [15:0] s4_dp_reg;
    logic        s4_late_reg;
    logic [29:0] s4_prod;

    logic [5:0]  s5_c_reg;
    logic [11:0] s5_rem_reg;
    logic [11:0] s5_rem_next;
    logic        s5_late_reg;
    logic [16:0] s5_diff;

    logic [5:0]  s6_c_reg;
    logic [5:0]  s6_c_next;
    logic [10:0] s6_rem_reg;
    logic [10:0] s6_rem_next;
    logic        s6_late_reg;
    logic        s6_ge;

    logic [8:0]  s7_doy_reg;
    logic [8:0]  s7_doy_next;
    logic [2:0]  s7_vm_reg;
    logic [2:0]  s7_vm_next;
    logic [2:0]  s7_vo_reg;
    logic [2:0]  s7_vo_next;
    logic        s7_late_reg;
    logic [1:0]  s7_yoe;
    logic [10:0] s7_base_days;
    logic [7:0]  s7_base;

    logic        s8_summer_reg;
    logic        s8_summer_next;
    logic [9:0]  s8_mar_sum;
    logic [9:0]  s8_oct_sum;

    assign busy = 1'b0;

    always_comb
    begin
        valid_next = {valid_reg[EUSTO_LATENCY-2:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: clamp to the end of 2099 and estimate the day number.
    always_comb
    begin
        s1_t_next = (utc_seconds > LAST_SECOND_2099) ? LAST_SECOND_2099 : utc_seconds;
        s1_prod   = {23'd0, s1_t_next[31:7]} * {25'd0, DAY_RECIP};
        s1_q_next = s1_prod[47:32];
    end

    // Stage 2: second of the day, which may still exceed one day.
    always_comb
    begin
        s2_diff   = {1'b0, s1_t_reg} - ({17'd0, s1_q_reg} * {16'd0, SECONDS_PER_DAY});
        s2_r_next = s2_diff[17:0];
    end

    // Stage 3: correct the day estimate, flag times from 01:00 and shift the epoch to 1968-03-01.
    always_comb
    begin
        s3_ge        = (s2_r_reg >= {1'b0, SECONDS_PER_DAY});
        s3_r         = s3_ge ? (s2_r_reg - {1'b0, SECONDS_PER_DAY}) : s2_r_reg;
        s3_late_next = (s3_r >= SECONDS_PER_HOUR);
        s3_dp_next   = s2_q_reg + {15'd0, s3_ge} + EPOCH_SHIFT;
    end

    // Stage 4: estimate the four-year cycle.
    always_comb
    begin
        s4_prod   = {14'd0, s3_dp_reg} * {16'd0, CYCLE_RECIP};
        s4_c_next = s4_prod[29:24];
    end

    // Stage 5: day within the cycle, which may still exceed one cycle.
    always_comb
    begin
        s5_diff     = {1'b0, s4_dp_reg} - ({11'd0, s4_c_reg} * {6'd0, DAYS_PER_CYCLE});
        s5_rem_next = s5_diff[11:0];
    end

    // Stage 6: correct the cycle estimate.
    always_comb
    begin
        s6_ge       = (s5_rem_reg >= {1'b0, DAYS_PER_CYCLE});
        s6_c_next   = s5_c_reg + {5'd0, s6_ge};
        s6_rem_next = s6_ge ? 11'(s5_rem_reg - {1'b0, DAYS_PER_CYCLE}) : s5_rem_reg[10:0];
    end

    // Stage 7: year in the cycle, day of the year and the weekday terms.
    // The last day of a cycle is February 29 and stays in year three.
    // With year = 1968 + 4c + yoe, 5*year/4 mod 7 reduces to (3 + 5c + yoe) mod 7.
    always_comb
    begin
        if (s6_rem_reg >= 11'd1095)
        begin
            s7_yoe       = 2'd3;
            s7_base_days = 11'd1095;
        end
        else if (s6_rem_reg >= 11'd730)
        begin
            s7_yoe       = 2'd2;
            s7_base_days = 11'd730;
        end
        else if (s6_rem_reg >= 11'd365)
        begin
            s7_yoe       = 2'd1;
            s7_base_days = 11'd365;
        end
        else
        begin
            s7_yoe       = 2'd0;
            s7_base_days = 11'd0;
        end
        s7_doy_next = 9'(s6_rem_reg - s7_base_days);
        s7_base     = 8'd3 + ({2'd0, s6_c_reg} << 2) + {2'd0, s6_c_reg} + {6'd0, s7_yoe};
        s7_vm_next  = mod7(s7_base + 8'd4);
        s7_vo_next  = mod7(s7_base + 8'd1);
    end

    // Stage 8: the European rule. In March the day is doy + 1, in October
    // doy - 213, and the last Sunday is 31 minus the weekday term.
    always_comb
    begin
        s8_mar_sum = {1'b0, s7_doy_reg} + {7'd0, s7_vm_reg};
        s8_oct_sum = {1'b0, s7_doy_reg} + {7'd0, s7_vo_reg};
        if (s7_doy_reg < 9'd31)
        begin
            s8_summer_next = (s8_mar_sum > 10'd30) || ((s8_mar_sum == 10'd30) && s7_late_reg);
        end
        else if (s7_doy_reg < OCT_FIRST_DOY)
        begin
            s8_summer_next = 1'b1;
        end
        else if (s7_doy_reg < 9'd245)
        begin
            s8_summer_next = (s8_oct_sum < 10'd244) ||
                             ((s8_oct_sum == 10'd244) && !s7_late_reg);
        end
        else
        begin
            s8_summer_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_t_reg      <= s1_t_next;
        s1_q_reg      <= s1_q_next;
        s2_q_reg      <= s1_q_reg;
        s2_r_reg      <= s2_r_next;
        s3_dp_reg     <= s3_dp_next;
        s3_late_reg   <= s3_late_next;
        s4_c_reg      <= s4_c_next;
        s4_dp_reg     <= s3_dp_reg;
        s4_late_reg   <= s3_late_reg;
        s5_c_reg      <= s4_c_reg;
        s5_rem_reg    <= s5_rem_next;
        s5_late_reg   <= s4_late_reg;
        s6_c_reg      <= s6_c_next;
        s6_rem_reg    <= s6_rem_next;
        s6_late_reg   <= s5_late_reg;
        s7_doy_reg    <= s7_doy_next;
        s7_vm_reg     <= s7_vm_next;
        s7_vo_reg     <= s7_vo_next;
        s7_late_reg   <= s6_late_reg;
        s8_summer_reg <= s8_summer_next;
    end

    assign done           = valid_reg[EUSTO_LATENCY-1];
    assign is_summer      = s8_summer_reg;
    assign offset_seconds = s8_summer_reg ? SUMMER_OFFSET : WINTER_OFFSET;

endmodule

`default_nettype wire

### hw/rtl/eusto_checker.sv
`default_nettype none

`include "eu_summer_time_offset_top_macros.svh"

module eusto_checker
    import eusto_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] utc_seconds,
    input wire logic        done,
    input wire logic        is_summer,
    input wire logic [12:0] offset_seconds
);

    logic transfer;

    assign transfer = start && !busy;

    // Every transfer produces its result after the fixed pipeline latency.
    `EUSTO_ASSERT_DLY(a_latency, clk, rst_n, transfer, EUSTO_LATENCY, done)

    // A result never appears without a transfer the right number of cycles before.
    `EUSTO_ASSERT_IMP(a_no_spurious, clk, rst_n, done, $past(transfer, EUSTO_LATENCY))

    // The offset always agrees with the summer flag.
    `EUSTO_ASSERT_IMP(a_offset_match, clk, rst_n, done, (is_summer && offset_seconds == SUMMER_OFFSET) || (!is_summer && offset_seconds == WINTER_OFFSET))

    // Times past the end of 2099 clamp to late December, which is winter.
    `EUSTO_ASSERT_DLY(a_clamp_winter, clk, rst_n, transfer && (utc_seconds > LAST_SECOND_2099), EUSTO_LATENCY, !is_summer)

endmodule

bind eu_summer_time_offset_top eusto_checker u_eusto_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .utc_seconds    (utc_seconds),
    .done           (done),
    .is_summer      (is_summer),
    .offset_seconds (offset_seconds)
);

`default_nettype wire

### sim/tb_eu_summer_time_offset_top.sv
`default_nettype none

module tb_eu_summer_time_offset_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eusto_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SECS_PER_DAY = 86400;

    typedef struct packed {
        logic [31:0] utc;
        logic        is_summer;
        logic [12:0] offset_seconds;
    } local_offset_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] utc_seconds;
    logic        done;
    logic        is_summer;
    logic [12:0] offset_seconds;

    local_offset_t pending_offsets[$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    bit            idle_en = 1'b1;

    eu_summer_time_offset_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .utc_seconds    (utc_seconds),
        .done           (done),
        .is_summer      (is_summer),
        .offset_seconds (offset_seconds)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned yr, input int unsigned mon);
        case (mon)
            2:       return leap_year(yr) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // Days since 1970-01-01 for a civil date.
    function automatic int unsigned date_to_days(input int unsigned yr, input int unsigned mon,
                                                 input int unsigned dy);
        int unsigned n;
        n = 0;
        for (int unsigned y = 1970; y < yr; y++)
        begin
            n += leap_year(y) ? 366 : 365;
        end
        for (int unsigned m = 1; m < mon; m++)
        begin
            n += month_days(yr, m);
        end
        return n + dy - 1;
    endfunction

    // Day of the month of the last Sunday; 1970-01-01 was a Thursday.
    function automatic int unsigned last_sunday_of(input int unsigned yr, input int unsigned mon)
        ;
        int unsigned d31;
        d31 = date_to_days(yr, mon, 31);
        return 31 - ((d31 + 4) % 7);
    endfunction

    // UTC instant of the clock change, 01:00 on the last Sunday.
    function automatic int unsigned switch_instant(input int unsigned yr, input int unsigned mon);
        return date_to_days(yr, mon, last_sunday_of(yr, mon)) * SECS_PER_DAY + 3600;
    endfunction

    function automatic local_offset_t predict_offset(input logic [31:0] t);
        local_offset_t r;
        int unsigned   secs;
        int unsigned   days;
        int unsigned   hour;
        int unsigned   yr;
        int unsigned   mon;
        int unsigned   dy;
        int unsigned   ls;
        bit            summer;
        secs = (t > LAST_SECOND_2099) ? LAST_SECOND_2099 : t;
        days = secs / SECS_PER_DAY;
        hour = (secs % SECS_PER_DAY) / 3600;
        yr = 1970;
        while (days >= (leap_year(yr) ? 366 : 365))
        begin
            days -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        mon = 1;
        while (days >= month_days(yr, mon))
        begin
            days -= month_days(yr, mon);
            mon++;
        end
        dy = days + 1;
        if (mon < 3 || mon > 10)
        begin
            summer = 1'b0;
        end
        else if (mon > 3 && mon < 10)
        begin
            summer = 1'b1;
        end
        else
        begin
            ls = last_sunday_of(yr, mon);
            if (mon == 3)
            begin
                summer = (dy > ls) || (dy == ls && hour >= 1);
            end
            else
            begin
                summer = (dy < ls) || (dy == ls && hour < 1);
            end
        end
        r.utc            = t;
        r.is_summer      = summer;
        r.offset_seconds = summer ? SUMMER_OFFSET : WINTER_OFFSET;
        return r;
    endfunction

    // Expectations are queued at the start transfer; results are checked on done.
    always @(posedge clk)
    begin : check_results
        local_offset_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_offsets.push_back(predict_offset(utc_seconds));
            end
            if (done)
            begin
                if (pending_offsets.size() == 0)
                begin
                    $display("%0t: unexpected result, got is_summer %0d offset %0d",
                             $time, is_summer, offset_seconds);
                    error_count++;
                end
                else
                begin
                    want = pending_offsets.pop_front();
                    if (is_summer !== want.is_summer)
                    begin
                        $display("%0t: is_summer mismatch for t=%0d, expected %0d, got %0d",
                                 $time, want.utc, want.is_summer, is_summer);
                        error_count++;
                    end
                    if (offset_seconds !== want.offset_seconds)
                    begin
                        $display("%0t: offset_seconds mismatch for t=%0d, expected %0d, got %0d",
                                 $time, want.utc, want.offset_seconds, offset_seconds);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Start stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_time(input logic [31:0] t);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, 16) : 0;
        if (gap != 0)
        begin
            start       <= 1'b0;
            utc_seconds <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        utc_seconds <= t;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        int unsigned s;
        int unsigned o;
        idle_en = 1'b0;
        send_time(32'd0);
        send_time(32'd1);
        send_time(LAST_SECOND_2099);
        send_time(LAST_SECOND_2099 + 32'd1);
        send_time(32'hFFFF_FFFF);
        send_time(32'h8000_0000);
        s = switch_instant(2021, 3);
        send_time(s - 3601);
        send_time(s - 3600);
        send_time(s - 1);
        send_time(s);
        idle_en = 1'b1;
        o = switch_instant(2021, 10);
        send_time(o - 3601);
        send_time(o - 3600);
        send_time(o - 1);
        send_time(o);
        send_time(o + 82799);
        send_time(date_to_days(2000, 2, 29) * SECS_PER_DAY);
        send_time(date_to_days(2096, 2, 29) * SECS_PER_DAY + 86399);
        send_time(switch_instant(2099, 3));
        send_time(switch_instant(1970, 10) - 1);
    endtask

    // Timestamps clustered around the March and October clock changes of random years.
    task automatic test_switchover_windows(input int unsigned count);
        int unsigned base;
        int          delta;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            base = switch_instant($urandom_range(1970, 2099), $urandom_range(0, 1) ? 3 : 10);
            case ($urandom_range(0, 2))
                0:       delta = int'($urandom_range(0, 2)) - 1;
                1:       delta = int'($urandom_range(0, 8000)) - 4000;
                default: delta = int'($urandom_range(0, 4 * SECS_PER_DAY)) - 2 * SECS_PER_DAY;
            endcase
            send_time(base + delta);
        end
    endtask

    task automatic test_change_months(input int unsigned count);
        int unsigned yr;
        int unsigned mon;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            yr  = $urandom_range(1970, 2099);
            mon = $urandom_range(0, 1) ? 3 : 10;
            send_time(date_to_days(yr, mon, $urandom_range(1, 31)) * SECS_PER_DAY
                      + $urandom_range(0, SECS_PER_DAY - 1));
        end
    endtask

    task automatic test_uniform_range(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            send_time($urandom_range(0, LAST_SECOND_2099));
        end
    endtask

    // Full 32-bit words, including values past 2099 that saturate.
    task automatic test_full_word(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                idle_en = ($urandom_range(0, 3) != 0);
            end
            send_time($urandom);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        utc_seconds <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_switchover_windows(250);
        test_change_months(100);
        test_uniform_range(250);
        test_full_word(50);

        start <= 1'b0;
        @(posedge clk);
        while (pending_offsets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (EUSTO_LATENCY + 4) @(posedge clk);

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
